/* rtl/xoshiro256_generator_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef XOSHIRO256_GENERATOR_TOP_DEFINES_SVH
`define XOSHIRO256_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define GEN_ASSERT_IMPL(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define GEN_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/xsg_pkg.sv */
package xsg_pkg;

   localparam int WORD_W  = 64;
   localparam int GEN_WORDS = 4;
   localparam int WIDX_W  = $clog2(GEN_WORDS);
   localparam int MODE_W  = 2;
   localparam int HALF_W  = WORD_W / 2;

   localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
   localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;

   localparam int ROT_PP  = 23;
   localparam int ROT_SS  = 7;
   localparam int SHL_ADV = 17;
   localparam int ROT_ADV = 45;
   localparam int MIX_SH0 = 30;
   localparam int MIX_SH1 = 27;
   localparam int MIX_SH2 = 31;

   localparam logic [MODE_W-1:0] MODE_DRAW_PP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DRAW_SS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESEED  = 2'd2;

   // multiply partial-product phases
   localparam logic [1:0] MUL_LL = 2'd0;
   localparam logic [1:0] MUL_LH = 2'd1;
   localparam logic [1:0] MUL_HL = 2'd2;

   typedef struct packed {
      logic       seed_load;   // acc <= seed, word index <= 0
      logic       seed_zero;   // seed with 0 instead of the item's seed
      logic       step_add;    // acc += gamma, x <= mix of new acc
      logic       mul_en;
      logic [1:0] mul_phase;
      logic       mul_b;       // second mix constant
      logic       load_xb;     // x <= p ^ (p >> 27)
      logic       store_word;  // w[idx] <= finalized p
      logic       draw_en;     // scramble + advance, load result
      logic       draw_star;   // ** scrambler
   } dp_cmd_type;

   typedef struct packed {
      logic last_word;
   } dp_status_type;

   function automatic logic [WORD_W-1:0] rotl64(logic [WORD_W-1:0] x, int amt);
      return (x << amt) | (x >> (WORD_W - amt));
   endfunction

endpackage

/* rtl/xsg_datapath.sv */
module xsg_datapath (
   input  logic                        clock,
   input  xsg_pkg::dp_cmd_type         cmd,
   input  logic [xsg_pkg::WORD_W-1:0]  seed_value,
   output xsg_pkg::dp_status_type      status,
   output logic [xsg_pkg::WORD_W-1:0]  random_word
);
   import xsg_pkg::*;

   logic [WORD_W-1:0] w_ff [GEN_WORDS];
   logic [WORD_W-1:0] w_in [GEN_WORDS];
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] p_ff, p_in;
   logic [WIDX_W-1:0] idx_ff, idx_in;
   logic [WORD_W-1:0] word_ff, word_in;

   logic [WORD_W-1:0] acc_next, mul_c, prod, fin;
   logic [HALF_W-1:0] mul_a, mul_b;
   logic [WORD_W-1:0] pp_sum, pp_x5, pp_r, ss_r, scr;
   logic [WORD_W-1:0] a02, a31, t17;

   // one shared 32x32 multiplier, low 64 bits built over three phases
   always_comb begin
      mul_c = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;
      mul_a = x_ff[HALF_W-1:0];
      mul_b = mul_c[HALF_W-1:0];
      case (cmd.mul_phase)
         MUL_LL: begin
            mul_a = x_ff[HALF_W-1:0];
            mul_b = mul_c[HALF_W-1:0];
         end
         MUL_LH: begin
            mul_a = x_ff[HALF_W-1:0];
            mul_b = mul_c[WORD_W-1:HALF_W];
         end
         MUL_HL: begin
            mul_a = x_ff[WORD_W-1:HALF_W];
            mul_b = mul_c[HALF_W-1:0];
         end
         default: begin
            mul_a = x_ff[HALF_W-1:0];
            mul_b = mul_c[HALF_W-1:0];
         end
      endcase
      prod = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
   end

   assign acc_next = acc_ff + GOLDEN_GAMMA;
   assign fin      = p_ff ^ (p_ff >> MIX_SH2);

   // scramblers
   always_comb begin
      pp_sum = w_ff[0] + w_ff[3];
      pp_r   = rotl64(pp_sum, ROT_PP) + w_ff[0];
      pp_x5  = w_ff[1] + (w_ff[1] << 2);
      ss_r   = rotl64(pp_x5, ROT_SS);
      scr    = cmd.draw_star ? (ss_r + (ss_r << 3)) : pp_r;
   end

   assign a02 = w_ff[2] ^ w_ff[0];
   assign a31 = w_ff[3] ^ w_ff[1];
   assign t17 = w_ff[1] << SHL_ADV;

   always_comb begin
      acc_in  = acc_ff;
      x_in    = x_ff;
      p_in    = p_ff;
      idx_in  = idx_ff;
      word_in = word_ff;
      for (int i = 0; i < GEN_WORDS; i++) w_in[i] = w_ff[i];

      if (cmd.seed_load) begin
         acc_in = cmd.seed_zero ? '0 : seed_value;
         idx_in = '0;
      end
      if (cmd.step_add) begin
         acc_in = acc_next;
         x_in   = acc_next ^ (acc_next >> MIX_SH0);
      end
      if (cmd.load_xb) x_in = p_ff ^ (p_ff >> MIX_SH1);
      if (cmd.mul_en) begin
         if (cmd.mul_phase == MUL_LL) begin
            p_in = prod;
         end else begin
            p_in[WORD_W-1:HALF_W] = p_ff[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
         end
      end
      if (cmd.store_word) begin
         w_in[idx_ff] = fin;
         idx_in       = idx_ff + 1'b1;
      end
      if (cmd.draw_en) begin
         word_in = scr;
         w_in[0] = w_ff[0] ^ a31;
         w_in[1] = w_ff[1] ^ a02;
         w_in[2] = a02 ^ t17;
         w_in[3] = rotl64(a31, ROT_ADV);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      p_ff    <= p_in;
      idx_ff  <= idx_in;
      word_ff <= word_in;
      for (int i = 0; i < GEN_WORDS; i++) w_ff[i] <= w_in[i];
   end

   assign status.last_word = (idx_ff == WIDX_W'(GEN_WORDS - 1));
   assign random_word      = word_ff;

endmodule

/* rtl/xsg_controller.sv */
module xsg_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [xsg_pkg::MODE_W-1:0]  req_mode,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  xsg_pkg::dp_status_type      status,
   output xsg_pkg::dp_cmd_type         cmd
);
   import xsg_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_ADD   = 11'b00000000010,
      ST_MA0   = 11'b00000000100,
      ST_MA1   = 11'b00000001000,
      ST_MA2   = 11'b00000010000,
      ST_XB    = 11'b00000100000,
      ST_MB0   = 11'b00001000000,
      ST_MB1   = 11'b00010000000,
      ST_MB2   = 11'b00100000000,
      ST_STORE = 11'b01000000000,
      ST_DRAW  = 11'b10000000000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic seeded_ff, seeded_in;
   logic pend_ff, pend_in;
   logic pend_star_ff, pend_star_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      seeded_in    = seeded_ff;
      pend_in      = pend_ff;
      pend_star_in = pend_star_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_mode)
                  MODE_RESEED: begin
                     cmd.seed_load = 1'b1;
                     seeded_in     = 1'b1;
                     state_in      = ST_ADD;
                  end
                  MODE_DRAW_PP, MODE_DRAW_SS: begin
                     if (seeded_ff) begin
                        cmd.draw_en   = 1'b1;
                        cmd.draw_star = (req_mode == MODE_DRAW_SS);
                        rsp_valid_in  = 1'b1;
                     end else begin
                        cmd.seed_load = 1'b1;
                        cmd.seed_zero = 1'b1;
                        seeded_in     = 1'b1;
                        pend_in       = 1'b1;
                        pend_star_in  = (req_mode == MODE_DRAW_SS);
                        state_in      = ST_ADD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD: begin
            cmd.step_add = 1'b1;
            state_in     = ST_MA0;
         end
         ST_MA0: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = MUL_LL;
            state_in      = ST_MA1;
         end
         ST_MA1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = MUL_LH;
            state_in      = ST_MA2;
         end
         ST_MA2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = MUL_HL;
            state_in      = ST_XB;
         end
         ST_XB: begin
            cmd.load_xb = 1'b1;
            state_in    = ST_MB0;
         end
         ST_MB0: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_b     = 1'b1;
            cmd.mul_phase = MUL_LL;
            state_in      = ST_MB1;
         end
         ST_MB1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_b     = 1'b1;
            cmd.mul_phase = MUL_LH;
            state_in      = ST_MB2;
         end
         ST_MB2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_b     = 1'b1;
            cmd.mul_phase = MUL_HL;
            state_in      = ST_STORE;
         end
         ST_STORE: begin
            cmd.store_word = 1'b1;
            if (!status.last_word) begin
               state_in = ST_ADD;
            end else if (pend_ff) begin
               state_in = ST_DRAW;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAW: begin
            // output slot was free when the draw item was taken
            cmd.draw_en   = 1'b1;
            cmd.draw_star = pend_star_ff;
            rsp_valid_in  = 1'b1;
            pend_in       = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         pend_star_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         pend_ff      <= pend_in;
         pend_star_ff <= pend_star_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/xoshiro256_generator_top.sv */
// Draw (mode 0/1) on a seeded state: result valid the next cycle after accept,
// one item every cycle while results are taken.
// Reseed (mode 2): 4 splitmix64 words, built one after another on one 32x32 multiplier.
// First draw after reset seeds with 0 first, then draws; no new item is taken meanwhile.
// Reset (synchronous, active high) clears control and the seeded flag; state words load on seeding.
module xoshiro256_generator_top (
   input  logic                        clock,
   input  logic                        reset,
   // input items
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [xsg_pkg::WORD_W-1:0]  req_tdata,   // [63:0] seed_value
   input  logic [xsg_pkg::MODE_W-1:0]  req_tuser,   // [1:0] mode
   // result items
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [xsg_pkg::WORD_W-1:0]  rsp_tdata    // [63:0] random_word
);
   import xsg_pkg::*;

   // Controller sequences the splitmix64 seeding (add, mix-A multiply in three
   // partial products, xor-shift, mix-B likewise, store) and issues draws. Datapath holds
   // the 256-bit state, the splitmix accumulator and the result register.
   dp_cmd_type    cmd;
   dp_status_type status;

   xsg_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Result register sits in the datapath; it only loads on a draw, which the
   // controller allows only when the slot is empty or being emptied.
   xsg_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .seed_value  (req_tdata),
      .status      (status),
      .random_word (rsp_tdata)
   );

endmodule

/* rtl/xsg_checker.sv */
`include "xoshiro256_generator_top_defines.svh"

module xsg_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [xsg_pkg::MODE_W-1:0]  req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [xsg_pkg::WORD_W-1:0]  rsp_tdata
);
   import xsg_pkg::*;

   `GEN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp item dropped while stalled")
   `GEN_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp data changed while stalled")
   `GEN_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "rsp valid right after reset")
   `GEN_ASSERT_NEXT(a_reseed_silent, clock, reset, req_tvalid && req_tready && (req_tuser == MODE_RESEED), !rsp_tvalid, "reseed item gave a result")
   `GEN_ASSERT_IMPL(a_no_take_stalled, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "req taken with stalled result")

endmodule

bind xoshiro256_generator_top xsg_checker u_checker (.*);

/* tb/xoshiro256_generator_top_test.sv */
module xoshiro256_generator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import xsg_pkg::*;

   // Mode value 3 has no meaning: the block drops the item.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 930;
   localparam int SETTLE_CYCLES = 60;     // past a full reseed plus a draw
   localparam int DRAIN_LIMIT   = 20000;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      word_type          seed;
      logic              yields_word;   // typed in: does this item give a result?
   } stim_row_type;

   localparam word_type ONES = 64'hffff_ffff_ffff_ffff;

   // Directed items. Result values come from the predictor; only whether an item
   // gives a result is typed in.
   localparam stim_row_type DIRECTED_ROWS [22] = '{
      '{MODE_DRAW_PP, 64'h0,                  1'b1},  // draw right after reset: implicit zero seed
      '{MODE_DRAW_SS, ONES,                   1'b1},  // seed field ignored on a draw
      '{MODE_UNUSED,  ONES,                   1'b0},  // dropped, must not reseed
      '{MODE_DRAW_PP, 64'h0,                  1'b1},
      '{MODE_RESEED,  64'h0,                  1'b0},  // restart the zero-seeded sequence
      '{MODE_DRAW_SS, 64'h0,                  1'b1},
      '{MODE_RESEED,  ONES,                   1'b0},
      '{MODE_DRAW_PP, 64'h1,                  1'b1},
      '{MODE_DRAW_SS, 64'h0,                  1'b1},
      '{MODE_RESEED,  64'h8000_0000_0000_0000, 1'b0},
      '{MODE_DRAW_PP, 64'h0,                  1'b1},
      '{MODE_RESEED,  64'h1,                  1'b0},  // back-to-back reseeds, last wins
      '{MODE_RESEED,  64'h5555_5555_5555_5555, 1'b0},
      '{MODE_RESEED,  64'haaaa_aaaa_aaaa_aaaa, 1'b0},
      '{MODE_DRAW_SS, 64'h0,                  1'b1},
      '{MODE_DRAW_PP, 64'h0,                  1'b1},
      '{MODE_RESEED,  64'h61c8_8646_80b5_83eb, 1'b0},  // first gamma step wraps to zero
      '{MODE_DRAW_PP, 64'h0,                  1'b1},
      '{MODE_UNUSED,  64'h0,                  1'b0},
      '{MODE_DRAW_SS, 64'haaaa_aaaa_aaaa_aaaa, 1'b1},
      '{MODE_RESEED,  64'h7fff_ffff_ffff_ffff, 1'b0},
      '{MODE_DRAW_PP, 64'h5555_5555_5555_5555, 1'b1}
   };

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [WORD_W-1:0] req_tdata  = '0;   // [63:0] seed_value
   logic [MODE_W-1:0] req_tuser  = '0;   // [1:0] mode
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [WORD_W-1:0] rsp_tdata;        // [63:0] random_word

   int idle_pct  = 26;   // sender gap chance per cycle, percent
   int stall_pct = 49;   // receiver stall chance per cycle, percent
   int failures  = 0;

   word_type expected_words [$];
   logic     listed_yields [$];

   // generator state as the predictor sees it
   word_type gen_state [GEN_WORDS];
   logic     gen_seeded;

   xoshiro256_generator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic word_type rotate_left(word_type v, int unsigned amt);
      if (amt == 0)
         return v;
      return (v << amt) | (v >> (WORD_W - amt));
   endfunction

   // four splitmix64 outputs in a row fill the state
   function automatic void splitmix_fill(word_type seed);
      word_type acc;
      word_type z;
      int       i;
      acc = seed;
      for (i = 0; i < GEN_WORDS; i++) begin
         acc = acc + GOLDEN_GAMMA;
         z   = (acc ^ (acc >> MIX_SH0)) * MIX_MUL_A;
         z   = (z ^ (z >> MIX_SH1)) * MIX_MUL_B;
         gen_state[i] = z ^ (z >> MIX_SH2);
      end
      gen_seeded = 1'b1;
   endfunction

   // Returns 1 when the item gives a word, which then is in word.
   function automatic logic predict_word(logic [MODE_W-1:0] mode, word_type seed,
                                         output word_type word);
      word_type t;
      word = '0;
      if (mode == MODE_RESEED) begin
         splitmix_fill(seed);
         return 1'b0;
      end
      if (mode == MODE_UNUSED)
         return 1'b0;
      if (!gen_seeded)
         splitmix_fill('0);
      if (mode == MODE_DRAW_PP)
         word = rotate_left(gen_state[0] + gen_state[3], ROT_PP) + gen_state[0];
      else
         word = rotate_left(gen_state[1] * 64'd5, ROT_SS) * 64'd9;
      // state update, same for both scramblers
      t = gen_state[1] << SHL_ADV;
      gen_state[2] = gen_state[2] ^ gen_state[0];
      gen_state[3] = gen_state[3] ^ gen_state[1];
      gen_state[1] = gen_state[1] ^ gen_state[2];
      gen_state[0] = gen_state[0] ^ gen_state[3];
      gen_state[2] = gen_state[2] ^ t;
      gen_state[3] = rotate_left(gen_state[3], ROT_ADV);
      return 1'b1;
   endfunction

   // Both handshakes are sampled here, on pre-edge values.
   always @(posedge clock) begin : track_words
      word_type predicted;
      word_type want;
      logic     yields;
      logic     listed;
      if (reset) begin
         foreach (gen_state[i])
            gen_state[i] = '0;
         gen_seeded = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            yields = predict_word(req_tuser, req_tdata, predicted);
            if (yields)
               expected_words.push_back(predicted);
            if (listed_yields.size() != 0) begin
               listed = listed_yields.pop_front();
               if (listed != yields) begin
                  $display("%0t: mode %0d result count, expected %0d, got %0d",
                           $time, req_tuser, listed, yields);
                  failures++;
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: random_word with none expected, expected none, got %h",
                        $time, rsp_tdata);
               failures++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: random_word mismatch, expected %h, got %h",
                           $time, want, rsp_tdata);
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Gaps come before the item, so valid is never lowered and raised in one step.
   task automatic send_item(logic [MODE_W-1:0] mode, word_type seed);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= seed;
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and wait for every outstanding word.
   task automatic drain_words();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   initial begin : stimulus
      logic [MODE_W-1:0] mode;
      word_type          seed;
      int                pick;
      int                n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         listed_yields.push_back(DIRECTED_ROWS[i].yields_word);
         send_item(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].seed);
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            // full hold-off, then swap which side idles more
            drain_words();
            idle_pct  = 49;
            stall_pct = 26;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         pick = $urandom_range(99);
         if (pick < 44)
            mode = MODE_DRAW_PP;
         else if (pick < 88)
            mode = MODE_DRAW_SS;
         else if (pick < 96)
            mode = MODE_RESEED;
         else
            mode = MODE_UNUSED;
         case ($urandom_range(15))
            0: seed = '0;
            1: seed = ONES;
            2: seed = word_type'(1) << $urandom_range(63);
            3: seed = ~(word_type'(1) << $urandom_range(63));
            default: seed = {$urandom, $urandom};
         endcase
         send_item(mode, seed);
      end

      drain_words();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         $display("%0t: words still outstanding, expected 0, got %0d",
                  $time, expected_words.size());
         failures++;
      end
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
